[hdl/sbsm_pkg.sv]
package sbsm_pkg;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned MAP_W    = 18;
  localparam int unsigned SHIFT_W  = 5;
  localparam logic [2:0]  SHIFT_LEN = 3'd5;
  localparam logic [1:0]  HOLDOFF_ARM = 2'd2;

  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_WRITE   = 3'd1,
    FUNC_PROG    = 3'd2,
    FUNC_PATTERN = 3'd3,
    FUNC_NAME    = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    TGT_CTRL  = 2'd0,
    TGT_PAT0  = 2'd1,
    TGT_PAT1  = 2'd2,
    TGT_PROG  = 2'd3
  } target_t;

  typedef enum logic [1:0] {
    MIR_PAGE0 = 2'd0,
    MIR_PAGE1 = 2'd1,
    MIR_A10   = 2'd2,
    MIR_A11   = 2'd3
  } mirror_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } in_word_t;

  typedef struct packed {
    logic [MAP_W-1:0] mapped_addr;
    logic             ram_off;
    logic             write_taken;
  } out_word_t;

endpackage

[hdl/serial_bank_switch_mapper.sv]
// Serial bank-switch mapper. Each input word (tick, register write, program,
// pattern or nametable lookup) yields exactly one result word carrying the
// translated address, the work RAM disable flag after the word, and whether
// a write was taken. It accepts one word per cycle while in_stall is low:
// all mapping and register-update logic is a single combinational pass from
// the state registers into the result register. A one-word skid buffer behind
// the result register keeps input flowing while the result side stalls;
// in_stall rises only once that buffer is full.
module serial_bank_switch_mapper
  import sbsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic [1:0]         holdoff_r, holdoff_nxt;
  logic [2:0]         shift_count_r, shift_count_nxt;
  logic [SHIFT_W-1:0] shift_value_r, shift_value_nxt;
  logic               pattern_mode_r, pattern_mode_nxt;
  logic               prog_half_r, prog_half_nxt;
  logic               prog_fixed_r, prog_fixed_nxt;
  logic [1:0]         mirror_r, mirror_nxt;
  logic [SHIFT_W-1:0] pat_bank0_r, pat_bank0_nxt;
  logic [SHIFT_W-1:0] pat_bank1_r, pat_bank1_nxt;
  logic               ram_dis_r, ram_dis_nxt;
  logic [3:0]         prog_bank_r, prog_bank_nxt;

  out_word_t main_r, main_nxt;
  out_word_t skid_r, skid_nxt;
  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;

  logic      in_acc;
  logic      out_take;
  out_word_t res;

  logic [SHIFT_W-1:0] shifted;
  logic [2:0]         cnt_inc;
  logic [3:0]         pbank;
  logic [SHIFT_W-1:0] cbank;
  logic               page;

  assign in_acc   = in_valid && !skid_v_r;
  assign out_take = main_v_r && !out_stall;
  assign in_stall = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  assign shifted = {in_data.data[0], shift_value_r[SHIFT_W-1:1]};
  assign cnt_inc = shift_count_r + 3'd1;

  always_comb begin
    pbank = {prog_bank_r[3:1], in_data.addr[14]};
    if (prog_half_r) begin
      if (in_data.addr[14] != prog_fixed_r) begin
        pbank = prog_bank_r;
      end else begin
        pbank = {4{in_data.addr[14]}};
      end
    end
    if (pattern_mode_r) begin
      cbank = in_data.addr[12] ? pat_bank1_r : pat_bank0_r;
    end else begin
      cbank = {pat_bank0_r[SHIFT_W-1:1], in_data.addr[12]};
    end
    case (mirror_r)
      MIR_PAGE0: page = 1'b0;
      MIR_PAGE1: page = 1'b1;
      MIR_A10:   page = in_data.addr[10];
      MIR_A11:   page = in_data.addr[11];
      default:   page = 1'b0;
    endcase
  end

  always_comb begin
    holdoff_nxt      = holdoff_r;
    shift_count_nxt  = shift_count_r;
    shift_value_nxt  = shift_value_r;
    pattern_mode_nxt = pattern_mode_r;
    prog_half_nxt    = prog_half_r;
    prog_fixed_nxt   = prog_fixed_r;
    mirror_nxt       = mirror_r;
    pat_bank0_nxt    = pat_bank0_r;
    pat_bank1_nxt    = pat_bank1_r;
    ram_dis_nxt      = ram_dis_r;
    prog_bank_nxt    = prog_bank_r;
    res.mapped_addr  = '0;
    res.write_taken  = 1'b0;
    case (in_data.func)
      FUNC_TICK: begin
        if (holdoff_r != 2'd0) begin
          holdoff_nxt = holdoff_r - 2'd1;
        end
      end
      FUNC_WRITE: begin
        if (holdoff_r == 2'd0) begin
          res.write_taken = 1'b1;
          holdoff_nxt     = HOLDOFF_ARM;
          if (in_data.data[7]) begin
            shift_count_nxt = '0;
            shift_value_nxt = '0;
            prog_half_nxt   = 1'b1;
            prog_fixed_nxt  = 1'b1;
          end else begin
            shift_value_nxt = shifted;
            shift_count_nxt = cnt_inc;
            if (cnt_inc == SHIFT_LEN) begin
              shift_count_nxt = '0;
              case (in_data.addr[14:13])
                TGT_CTRL: begin
                  pattern_mode_nxt = shifted[4];
                  prog_half_nxt    = shifted[3];
                  prog_fixed_nxt   = shifted[2];
                  mirror_nxt       = shifted[1:0];
                end
                TGT_PAT0: pat_bank0_nxt = shifted;
                TGT_PAT1: pat_bank1_nxt = shifted;
                TGT_PROG: begin
                  ram_dis_nxt   = shifted[4];
                  prog_bank_nxt = shifted[3:0];
                end
                default: ;
              endcase
            end
          end
        end
      end
      FUNC_PROG:    res.mapped_addr = {pbank, in_data.addr[13:0]};
      FUNC_PATTERN: res.mapped_addr = {1'b0, cbank, in_data.addr[11:0]};
      FUNC_NAME:    res.mapped_addr = {7'd0, page, in_data.addr[9:0]};
      default: ;
    endcase
    res.ram_off = ram_dis_nxt;
  end

  always_comb begin
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (!main_v_r || out_take) begin
      main_v_nxt = skid_v_r || in_acc;
      main_nxt   = skid_v_r ? skid_r : res;
      skid_v_nxt = 1'b0;
    end else if (in_acc) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
    if (!rst_n) begin
      main_v_r       <= 1'b0;
      skid_v_r       <= 1'b0;
      holdoff_r      <= '0;
      shift_count_r  <= '0;
      shift_value_r  <= '0;
      pattern_mode_r <= 1'b0;
      prog_half_r    <= 1'b1;
      prog_fixed_r   <= 1'b1;
      mirror_r       <= MIR_PAGE0;
      pat_bank0_r    <= 5'd0;
      pat_bank1_r    <= 5'd1;
      ram_dis_r      <= 1'b0;
      prog_bank_r    <= '0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
      if (in_acc) begin
        holdoff_r      <= holdoff_nxt;
        shift_count_r  <= shift_count_nxt;
        shift_value_r  <= shift_value_nxt;
        pattern_mode_r <= pattern_mode_nxt;
        prog_half_r    <= prog_half_nxt;
        prog_fixed_r   <= prog_fixed_nxt;
        mirror_r       <= mirror_nxt;
        pat_bank0_r    <= pat_bank0_nxt;
        pat_bank1_r    <= pat_bank1_nxt;
        ram_dis_r      <= ram_dis_nxt;
        prog_bank_r    <= prog_bank_nxt;
      end
    end
  end

  a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid word held without a result word");

  a_holdoff_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.func == FUNC_WRITE && holdoff_r != 2'd0)
      |=> (holdoff_r == $past(holdoff_r) && shift_count_r == $past(shift_count_r)))
    else $error("held-off write changed mapper state");

  a_shift_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    shift_count_r < SHIFT_LEN)
    else $error("shift count beyond five bits");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !main_v_r) |=> main_v_r)
    else $error("accepted word produced no result");

endmodule
